// ===== rtl/core/counting_semaphore_wait_unit_macros.svh =====
// Assertion macros for the counting semaphore wait unit checker.
// No dependencies; included by files that assert.
`ifndef COUNTING_SEMAPHORE_WAIT_UNIT_MACROS_SVH
`define COUNTING_SEMAPHORE_WAIT_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CSW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csw assertion failed");

// next-cycle implication, disabled during reset
`define CSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csw assertion failed");

`endif

// ===== rtl/core/csw_pkg.sv =====
// Types and constants of the counting semaphore wait unit.
// No dependencies; used by every module of the unit.
package csw_pkg;

  localparam logic [1:0] REQ_INIT   = 2'd0;
  localparam logic [1:0] REQ_WAIT   = 2'd1;
  localparam logic [1:0] REQ_SIGNAL = 2'd2;

  localparam logic signed [15:0] CNT_MIN = 16'sh8000;
  localparam logic signed [15:0] CNT_MAX = 16'sh7fff;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         sem_id;
    logic signed [15:0] init_value;
    logic [3:0]         caller_thread;
  } csw_req_t;

  typedef struct packed {
    logic               caller_blocked;
    logic               wake_valid;
    logic [3:0]         wake_thread;
    logic signed [15:0] new_count;
  } csw_rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
  } csw_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_hit;
    logic scan_last;
  } csw_status_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } csw_state_e;

endpackage

// ===== rtl/core/csw_ctrl.sv =====
// Controller state machine of the counting semaphore wait unit.
// Depends on csw_pkg; drives the datapath csw_dp through command signals.
module csw_ctrl import csw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        result_valid_o,
  output csw_cmd_t    cmd_o,
  input  csw_status_t status_i
);

  csw_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start) state_d = ST_EXEC;
      ST_EXEC: state_d = status_i.need_scan ? ST_SCAN : ST_DONE;
      ST_SCAN: if (status_i.scan_hit || status_i.scan_last) state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_DONE);
  assign cmd_o.load     = (state_q == ST_IDLE) && start;
  assign cmd_o.exec     = (state_q == ST_EXEC);
  assign cmd_o.scan     = (state_q == ST_SCAN);

endmodule

// ===== rtl/core/csw_dp.sv =====
// Datapath of the counting semaphore wait unit: counts, thread table, ring scan.
// Depends on csw_pkg; commanded by csw_ctrl.
module csw_dp import csw_pkg::*; #(
  parameter int NUM_SEMS    = 8,
  parameter int NUM_THREADS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  csw_req_t    req_i,
  input  csw_cmd_t    cmd_i,
  output csw_status_t status_o,
  output csw_rsp_t    result_o
);

  localparam int SIW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int TIW = $clog2(NUM_THREADS);
  localparam logic [TIW-1:0] LAST_IDX = TIW'(NUM_THREADS - 1);

  logic signed [15:0] count_q [NUM_SEMS];
  logic signed [15:0] count_d [NUM_SEMS];
  logic               blocked_q [NUM_THREADS];
  logic               blocked_d [NUM_THREADS];
  logic [2:0]         wsem_q [NUM_THREADS];
  logic [2:0]         wsem_d [NUM_THREADS];
  csw_req_t           req_q, req_d;
  csw_rsp_t           rsp_q, rsp_d;
  logic [TIW-1:0]     ptr_q, ptr_d;
  logic [TIW-1:0]     steps_q, steps_d;

  logic               sem_ok, caller_ok;
  logic [SIW-1:0]     sidx;
  logic [TIW-1:0]     cidx;
  logic signed [15:0] cur_cnt, dec_cnt, inc_cnt;

  assign sem_ok    = (32'(req_q.sem_id) < NUM_SEMS);
  assign caller_ok = (32'(req_q.caller_thread) < NUM_THREADS);
  assign sidx      = SIW'(req_q.sem_id);
  assign cidx      = TIW'(req_q.caller_thread);
  assign cur_cnt   = count_q[sidx];
  assign dec_cnt   = (cur_cnt == CNT_MIN) ? CNT_MIN : cur_cnt - 16'sd1;
  assign inc_cnt   = (cur_cnt == CNT_MAX) ? CNT_MAX : cur_cnt + 16'sd1;

  assign status_o.need_scan = sem_ok && caller_ok && (req_q.req_type == REQ_SIGNAL);
  assign status_o.scan_hit  = blocked_q[ptr_q] && (wsem_q[ptr_q] == req_q.sem_id);
  assign status_o.scan_last = (steps_q == LAST_IDX);

  always_comb begin
    count_d   = count_q;
    blocked_d = blocked_q;
    wsem_d    = wsem_q;
    req_d     = req_q;
    rsp_d     = rsp_q;
    ptr_d     = ptr_q;
    steps_d   = steps_q;
    if (cmd_i.load) begin
      req_d = req_i;
    end
    if (cmd_i.exec) begin
      rsp_d = '0;
      if (sem_ok) begin
        rsp_d.new_count = cur_cnt;
        unique case (req_q.req_type)
          REQ_INIT: begin
            count_d[sidx]   = req_q.init_value;
            rsp_d.new_count = req_q.init_value;
          end
          REQ_WAIT: begin
            if (caller_ok) begin
              count_d[sidx]   = dec_cnt;
              rsp_d.new_count = dec_cnt;
              if (dec_cnt[15]) begin
                blocked_d[cidx]      = 1'b1;
                wsem_d[cidx]         = req_q.sem_id;
                rsp_d.caller_blocked = 1'b1;
              end
            end
          end
          REQ_SIGNAL: begin
            if (caller_ok) begin
              count_d[sidx]   = inc_cnt;
              rsp_d.new_count = inc_cnt;
              ptr_d           = (cidx == LAST_IDX) ? '0 : cidx + 1'b1;
              steps_d         = TIW'(1);
            end
          end
          default: ;
        endcase
      end
    end
    if (cmd_i.scan) begin
      if (status_o.scan_hit) begin
        blocked_d[ptr_q]  = 1'b0;
        rsp_d.wake_valid  = 1'b1;
        rsp_d.wake_thread = 4'(ptr_q);
      end else begin
        ptr_d   = (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
        steps_d = steps_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SEMS; i++) begin
        count_q[i] <= '0;
      end
      for (int i = 0; i < NUM_THREADS; i++) begin
        blocked_q[i] <= 1'b0;
        wsem_q[i]    <= '0;
      end
      ptr_q   <= '0;
      steps_q <= '0;
    end else begin
      count_q   <= count_d;
      blocked_q <= blocked_d;
      wsem_q    <= wsem_d;
      ptr_q     <= ptr_d;
      steps_q   <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
  end

  assign result_o = rsp_q;

endmodule

// ===== rtl/core/counting_semaphore_wait_unit.sv =====
// Counting semaphore wait unit: one request at a time, one result per request.
// Init and wait go from accept through the exec state to the result strobe; a valid
// signal also scans the ring until it wakes a thread blocked on the semaphore or has
// examined every other thread. A new request is taken the cycle after the strobe.
// Reset clears all counts and the blocked-thread table; no result is pending.
// Depends on csw_pkg, csw_ctrl and csw_dp.
module counting_semaphore_wait_unit import csw_pkg::*; #(
  parameter int NUM_SEMS    = 8,
  parameter int NUM_THREADS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  csw_req_t req_i,
  output logic     result_valid_o,
  output csw_rsp_t result_o
);

  csw_cmd_t    cmd;
  csw_status_t status;

  csw_ctrl u_csw_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd),
    .status_i       (status)
  );

  csw_dp #(
    .NUM_SEMS    (NUM_SEMS),
    .NUM_THREADS (NUM_THREADS)
  ) u_csw_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (result_o)
  );

endmodule

// ===== rtl/core/csw_checker.sv =====
// Port-level checks of the counting semaphore wait unit, bound to the top level.
// Depends on csw_pkg and counting_semaphore_wait_unit_macros.svh.
`include "counting_semaphore_wait_unit_macros.svh"

module csw_checker import csw_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input logic     result_valid_o,
  input csw_rsp_t result_o
);

  `CSW_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `CSW_ASSERT_NEXT(a_strobe_single, clk_i, rst_ni, result_valid_o, !result_valid_o && !busy)
  `CSW_ASSERT_IMPL(a_strobe_in_busy, clk_i, rst_ni, result_valid_o, busy)
  `CSW_ASSERT_IMPL(a_wake_zero, clk_i, rst_ni, result_valid_o && !result_o.wake_valid, result_o.wake_thread == 4'd0)
  `CSW_ASSERT_IMPL(a_block_negative, clk_i, rst_ni, result_valid_o && result_o.caller_blocked, result_o.new_count[15] && !result_o.wake_valid)

endmodule

bind counting_semaphore_wait_unit csw_checker u_csw_checker (.*);
